@@ design/qph_pkg.sv @@
// Package for the quadratic probe hash table: field widths, operation and
// status codes, register map, sequencer states and a small constant-modulo helper.
// Used by qph_mod_unit and quadratic_probe_hash_table_top; depends on nothing.
package qph_pkg;

    // Fixed widths of the configuration register, the result fields, the mode field and the APB port.
    localparam int CFG_W    = 15;
    localparam int SLOT_W   = 14;
    localparam int COUNT_W  = 15;
    localparam int FVAL_W   = 32;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    // Register map: one register, index taken from paddr[2].
    localparam logic [0:0]       REG_TABLE_SIZE   = 1'b0;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 15'd16384;

    // Operation codes of the mode field.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // Status codes of a result word.
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISSING  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd5;

    // Probe step constants: slot(i+1) - slot(i) = 4*i + 5.
    localparam logic [2:0] STEP_FIRST = 3'd5;
    localparam logic [2:0] STEP_GROW  = 3'd4;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } qph_state_t;

    // Reduce a small constant (at most 5) modulo a nonzero table size.
    function automatic logic [CFG_W-1:0] const_mod(input logic [2:0] c,
                                                   input logic [CFG_W-1:0] s);
        logic [CFG_W-1:0] r;
        r = CFG_W'(c);
        for (int k = 0; k < 5; k++) begin
            if (r >= s) begin
                r = r - s;
            end
        end
        return r;
    endfunction

endpackage

@@ design/quadratic_probe_hash_table_top.sv @@
// Top level of the quadratic probe hash table: sequencer, slot memory, APB register.
// Depends on qph_pkg and qph_mod_unit.
//
// Open-addressing hash table with quadratic probing in one single-port-write,
// registered-read slot memory of TABLE_DEPTH words. One word is taken at a time.
// An insert or search first reduces the key modulo the table size in the
// iterative modulo unit, then walks the probe sequence, each probe being a
// memory read followed by a compare. A clear sweeps the whole memory, one
// slot a cycle. After reset the same clearing pass runs before the first word
// is accepted; register writes are taken during it.
// The result word sits in an output register, so the next word is accepted
// while a result still waits to be taken.
module quadratic_probe_hash_table_top #(
    parameter int TABLE_DEPTH = 16384,
    parameter int KEY_BITS    = 24,
    parameter int VALUE_BITS  = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [qph_pkg::MODE_W-1:0]   mode,
    input  logic [KEY_BITS-1:0]          key,
    input  logic [VALUE_BITS-1:0]        value,
    // Output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [qph_pkg::STATUS_W-1:0] status,
    output logic [qph_pkg::SLOT_W-1:0]   slot,
    output logic [qph_pkg::FVAL_W-1:0]   found_value,
    output logic [qph_pkg::COUNT_W-1:0]  probe_count,
    // Configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qph_pkg::PADDR_W-1:0]  paddr,
    input  logic [qph_pkg::PDATA_W-1:0]  pwdata,
    output logic [qph_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int WORD_W = 1 + KEY_BITS + VALUE_BITS;
    localparam int CW     = qph_pkg::CFG_W;
    localparam int SW     = qph_pkg::SLOT_W;
    localparam int NW     = qph_pkg::COUNT_W;
    localparam int FW     = qph_pkg::FVAL_W;
    localparam int TW     = qph_pkg::STATUS_W;

    // Slot memory: valid bit, key, value.
    logic [WORD_W-1:0] mem [TABLE_DEPTH];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [WORD_W-1:0] rd_word_reg;

    // Control registers.
    qph_pkg::qph_state_t state_reg, state_next;
    logic [CW-1:0]       table_size_reg;
    logic [IDX_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                clr_cmd_reg, clr_cmd_next;
    logic                out_valid_reg, out_valid_next;

    // Payload registers.
    logic [qph_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [KEY_BITS-1:0]        key_reg, key_next;
    logic [VALUE_BITS-1:0]      value_reg, value_next;
    logic [CW-1:0]              size_reg, size_next;
    logic [CW-1:0]              pos_reg, pos_next;
    logic [CW-1:0]              delta_reg, delta_next;
    logic [CW-1:0]              inc4_reg, inc4_next;
    logic [NW-1:0]              probe_reg, probe_next;
    logic [TW-1:0]              res_status_reg, res_status_next;
    logic [SW-1:0]              res_slot_reg, res_slot_next;
    logic [FW-1:0]              res_value_reg, res_value_next;
    logic [NW-1:0]              res_count_reg, res_count_next;
    logic [TW-1:0]              status_reg, status_next;
    logic [SW-1:0]              slot_reg, slot_next;
    logic [FW-1:0]              found_value_reg, found_value_next;
    logic [NW-1:0]              probe_count_reg, probe_count_next;

    // Modulo unit handshake.
    logic          mod_start;
    logic          mod_done;
    logic [CW-1:0] mod_rem;

    logic          in_accept;
    logic          out_free;
    logic          cfg_write;
    logic [CW-1:0] eff_size;

    // Probe arithmetic and read-word fields.
    logic [CW:0]             pos_sum, pos_red;
    logic [CW:0]             delta_sum, delta_red;
    logic [CW-1:0]           pos_adv, delta_adv;
    logic [NW-1:0]           probe_inc;
    logic [IDX_W+CW-1:0]     pos_wide;
    logic                    rd_valid;
    logic [KEY_BITS-1:0]     rd_key;
    logic [VALUE_BITS-1:0]   rd_value;
    logic [FW+VALUE_BITS-1:0] fval_wide;
    logic                    key_match;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != qph_pkg::ST_IDLE);

    // Register write decode.
    assign cfg_write = psel && penable && pwrite
                       && (paddr[qph_pkg::PADDR_W-1:2] == qph_pkg::REG_TABLE_SIZE);
    assign pready    = 1'b1;

    always_comb
    begin
        if (paddr[qph_pkg::PADDR_W-1:2] == qph_pkg::REG_TABLE_SIZE)
        begin
            prdata = qph_pkg::PDATA_W'(table_size_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // Effective size: zero acts as one, anything above the depth acts as the depth.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = CW'(1);
        end
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            eff_size = CW'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    // Key reduction for the first probe slot.
    qph_mod_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (key),
        .divisor   (eff_size),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // Next probe slot and step, each reduced by one conditional subtract.
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, delta_reg};
    assign pos_red   = pos_sum - {1'b0, size_reg};
    assign pos_adv   = (pos_sum >= {1'b0, size_reg}) ? pos_red[CW-1:0] : pos_sum[CW-1:0];
    assign delta_sum = {1'b0, delta_reg} + {1'b0, inc4_reg};
    assign delta_red = delta_sum - {1'b0, size_reg};
    assign delta_adv = (delta_sum >= {1'b0, size_reg}) ? delta_red[CW-1:0]
                                                       : delta_sum[CW-1:0];
    assign probe_inc = probe_reg + NW'(1);

    // Memory address of the current probe slot.
    assign pos_wide  = {{IDX_W{1'b0}}, pos_reg};
    assign mem_raddr = pos_wide[IDX_W-1:0];

    // Fields of the word read last cycle.
    assign rd_valid  = rd_word_reg[WORD_W-1];
    assign rd_key    = rd_word_reg[VALUE_BITS +: KEY_BITS];
    assign rd_value  = rd_word_reg[VALUE_BITS-1:0];
    assign fval_wide = {{FW{1'b0}}, rd_value};
    assign key_match = (rd_key == key_reg);

    // Sequencer: next state, memory writes and result fields.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        clr_cmd_next     = clr_cmd_reg;
        out_valid_next   = out_valid_reg && out_stall;
        mode_next        = mode_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        size_next        = size_reg;
        pos_next         = pos_reg;
        delta_next       = delta_reg;
        inc4_next        = inc4_reg;
        probe_next       = probe_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_value_next   = res_value_reg;
        res_count_next   = res_count_reg;
        status_next      = status_reg;
        slot_next        = slot_reg;
        found_value_next = found_value_reg;
        probe_count_next = probe_count_reg;
        mod_start        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = mem_raddr;
        mem_wdata        = {1'b1, key_reg, value_reg};

        unique case (state_reg)
            qph_pkg::ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    if (clr_cmd_reg)
                    begin
                        res_status_next = qph_pkg::STATUS_CLEARED;
                        res_slot_next   = '0;
                        res_value_next  = '0;
                        res_count_next  = '0;
                        state_next      = qph_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = qph_pkg::ST_IDLE;
                    end
                end
            end

            qph_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    mode_next  = mode;
                    key_next   = key;
                    value_next = value;
                    size_next  = eff_size;
                    if (mode == qph_pkg::MODE_INSERT || mode == qph_pkg::MODE_SEARCH)
                    begin
                        mod_start  = 1'b1;
                        state_next = qph_pkg::ST_MOD;
                    end
                    else if (mode == qph_pkg::MODE_CLEAR)
                    begin
                        clr_cmd_next = 1'b1;
                        clr_cnt_next = '0;
                        state_next   = qph_pkg::ST_CLEAR;
                    end
                end
            end

            qph_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    pos_next   = mod_rem;
                    delta_next = qph_pkg::const_mod(qph_pkg::STEP_FIRST, size_reg);
                    inc4_next  = qph_pkg::const_mod(qph_pkg::STEP_GROW, size_reg);
                    probe_next = '0;
                    state_next = qph_pkg::ST_READ;
                end
            end

            qph_pkg::ST_READ:
            begin
                // The slot word is read at this edge.
                state_next = qph_pkg::ST_CHECK;
            end

            qph_pkg::ST_CHECK:
            begin
                res_slot_next  = '0;
                res_value_next = '0;
                res_count_next = '0;
                probe_next     = probe_inc;
                if (mode_reg == qph_pkg::MODE_INSERT)
                begin
                    if (!rd_valid || key_match)
                    begin
                        mem_we          = 1'b1;
                        res_status_next = rd_valid ? qph_pkg::STATUS_UPDATED
                                                   : qph_pkg::STATUS_INSERTED;
                        res_slot_next   = pos_reg[SW-1:0];
                        state_next      = qph_pkg::ST_DONE;
                    end
                    else if (probe_inc == NW'(size_reg))
                    begin
                        res_status_next = qph_pkg::STATUS_FULL;
                        state_next      = qph_pkg::ST_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_adv;
                        delta_next = delta_adv;
                        state_next = qph_pkg::ST_READ;
                    end
                end
                else
                begin
                    res_count_next = probe_inc;
                    if (rd_valid && key_match)
                    begin
                        res_status_next = qph_pkg::STATUS_FOUND;
                        res_slot_next   = pos_reg[SW-1:0];
                        res_value_next  = fval_wide[FW-1:0];
                        state_next      = qph_pkg::ST_DONE;
                    end
                    else if (!rd_valid || probe_inc == NW'(size_reg))
                    begin
                        res_status_next = qph_pkg::STATUS_MISSING;
                        state_next      = qph_pkg::ST_DONE;
                    end
                    else
                    begin
                        pos_next   = pos_adv;
                        delta_next = delta_adv;
                        state_next = qph_pkg::ST_READ;
                    end
                end
            end

            qph_pkg::ST_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    slot_next        = res_slot_reg;
                    found_value_next = res_value_reg;
                    probe_count_next = res_count_reg;
                    clr_cmd_next     = 1'b0;
                    state_next       = qph_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = qph_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state; reset starts the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qph_pkg::ST_CLEAR;
            table_size_reg <= qph_pkg::TABLE_SIZE_RESET;
            clr_cnt_reg    <= '0;
            clr_cmd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_cmd_reg   <= clr_cmd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                table_size_reg <= pwdata[CW-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        size_reg        <= size_next;
        pos_reg         <= pos_next;
        delta_reg       <= delta_next;
        inc4_reg        <= inc4_next;
        probe_reg       <= probe_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_value_reg   <= res_value_next;
        res_count_reg   <= res_count_next;
        status_reg      <= status_next;
        slot_reg        <= slot_next;
        found_value_reg <= found_value_next;
        probe_count_reg <= probe_count_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign found_value = found_value_reg;
    assign probe_count = probe_count_reg;

endmodule

@@ design/qph_mod_unit.sv @@
// Iterative modulo unit: reduces a key by the table size, one key bit a cycle.
// Depends on qph_pkg for the divisor width.
module qph_mod_unit #(
    parameter int KEY_BITS = 24
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [KEY_BITS-1:0]       dividend,
    input  logic [qph_pkg::CFG_W-1:0] divisor,
    output logic                      done,
    output logic [qph_pkg::CFG_W-1:0] remainder
);

    localparam int CW    = qph_pkg::CFG_W;
    localparam int CNT_W = $clog2(KEY_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [KEY_BITS-1:0] quo_reg, quo_next;
    logic [CW-1:0]       dsr_reg, dsr_next;
    logic [CW-1:0]       rem_reg, rem_next;

    logic [CW:0] trial;
    logic [CW:0] trial_sub;

    // One restoring step: shift in the next key bit, subtract when it fits.
    assign trial     = {rem_reg, quo_reg[KEY_BITS-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(KEY_BITS);
            quo_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next = quo_reg << 1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial_sub[CW-1:0];
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
